/* rtl/srde_pkg.sv */
// Shared types, constants and helper functions for the radix digit emitter.
`default_nettype none

package srde_pkg;

    // Field and storage widths
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned BASE_W      = 5;
    localparam int unsigned TABLE_W     = 64;
    localparam int unsigned TABLE_CHARS = 2 * TABLE_W / CHAR_W;
    localparam int unsigned DIGIT_W     = $clog2(TABLE_CHARS);
    localparam int unsigned MAX_BASE    = 16;
    localparam int unsigned MAX_DIGITS  = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int unsigned SLICE_W     = 8;
    localparam int unsigned SLICES      = VALUE_W / SLICE_W;
    localparam int unsigned SLICE_IDX_W = $clog2(SLICES);
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [1:0] CFG_BASE_SIZE = 2'd0;
    localparam logic [1:0] CFG_TABLE_LO  = 2'd1;
    localparam logic [1:0] CFG_TABLE_HI  = 2'd2;

    // Character codes and limits
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd126;
    localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

    // One classified request handed from front to back
    typedef struct packed {
        logic               err;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT,
        ST_ERR
    } t_back_state;

    // Pick digit character idx out of the two table words
    function automatic logic [CHAR_W-1:0] table_char(
        input logic [DIGIT_W-1:0] idx,
        input logic [TABLE_W-1:0] lo,
        input logic [TABLE_W-1:0] hi
    );
        logic [TABLE_W-1:0] word;
        word = idx[DIGIT_W-1] ? hi : lo;
        return word[{idx[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

    // Check radix range, character set and uniqueness of the characters in use
    function automatic logic base_ok(
        input logic [BASE_W-1:0]  size,
        input logic [TABLE_W-1:0] lo,
        input logic [TABLE_W-1:0] hi
    );
        logic [CHAR_W-1:0] c [TABLE_CHARS];
        logic              ok;
        ok = (size >= MIN_BASE) && (size <= BASE_W'(MAX_BASE));
        for (int i = 0; i < TABLE_CHARS; i++) begin
            c[i] = table_char(DIGIT_W'(i), lo, hi);
        end
        for (int i = 0; i < TABLE_CHARS; i++) begin
            if (BASE_W'(i) < size) begin
                if (c[i] == CH_PLUS || c[i] == CH_MINUS || c[i] < CH_LOW || c[i] > CH_HIGH) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < TABLE_CHARS; j++) begin
                    if (BASE_W'(j) < size && c[j] == c[i]) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

/* rtl/srde_front.sv */
// Front end: accepts values, takes sign and magnitude, flags an invalid base.
`default_nettype none

module srde_front (
    input  wire logic                          i_valid,
    input  wire logic signed [srde_pkg::VALUE_W-1:0] i_value,
    input  wire logic [srde_pkg::BASE_W-1:0]   i_base_size,
    input  wire logic [srde_pkg::TABLE_W-1:0]  i_table_lo,
    input  wire logic [srde_pkg::TABLE_W-1:0]  i_table_hi,
    input  wire logic                          i_q_full,
    output logic                               o_stall,
    output logic                               o_push,
    output srde_pkg::t_job                     o_job
);
    import srde_pkg::*;

    logic [VALUE_W-1:0] raw;

    // Stall while the queue has no room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Classify the request: sign, unsigned magnitude, base check
    assign raw        = i_value;
    assign o_job.neg  = raw[VALUE_W-1];
    assign o_job.mag  = raw[VALUE_W-1] ? VALUE_W'(~raw + 1'b1) : raw;
    assign o_job.err  = !base_ok(i_base_size, i_table_lo, i_table_hi);

endmodule

`default_nettype wire

/* rtl/srde_fifo.sv */
// Short queue of classified requests between front and back.
`default_nettype none

module srde_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  srde_pkg::t_job i_job,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_valid,
    output srde_pkg::t_job o_job
);
    import srde_pkg::*;

    localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* rtl/srde_back.sv */
// Back end: divides out digits by the radix, emits sign and digits MSB first or an error.
`default_nettype none

module srde_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  srde_pkg::t_job                    i_job,
    output logic                              o_pop,
    input  wire logic [srde_pkg::BASE_W-1:0]  i_base_size,
    input  wire logic [srde_pkg::TABLE_W-1:0] i_table_lo,
    input  wire logic [srde_pkg::TABLE_W-1:0] i_table_hi,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [srde_pkg::CHAR_W-1:0]       o_out_char,
    output logic                              o_last,
    output logic                              o_base_error
);
    import srde_pkg::*;

    t_back_state            r_state, n_state;
    logic [VALUE_W-1:0]     r_quo,   n_quo;
    logic [DIGIT_W-1:0]     r_rem,   n_rem;
    logic [SLICE_IDX_W-1:0] r_slice, n_slice;
    logic                   r_neg,   n_neg;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic [DIGIT_W-1:0]     r_dig [MAX_DIGITS];
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_out_char,  n_out_char;
    logic                   r_out_last,  n_out_last;
    logic                   r_out_err,   n_out_err;

    logic [SLICE_W-1:0]     div_q;
    logic [DIGIT_W-1:0]     div_rem;
    logic [VALUE_W-1:0]     div_quo;
    logic [DIGIT_W:0]       div_t;
    logic                   dig_we;
    logic [DIG_IDX_W-1:0]   rd_idx;
    logic                   out_free;

    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_last       = r_out_last;
    assign o_base_error = r_out_err;

    // Long division of the top slice by the radix, one bit per step
    always_comb begin
        div_rem = r_rem;
        div_q   = '0;
        div_t   = '0;
        for (int k = SLICE_W - 1; k >= 0; k--) begin
            div_t = {div_rem, r_quo[VALUE_W - SLICE_W + k]};
            if (div_t >= i_base_size) begin
                div_q[k] = 1'b1;
                div_rem  = DIGIT_W'(div_t - i_base_size);
            end else begin
                div_rem  = div_t[DIGIT_W-1:0];
            end
        end
        div_quo = {r_quo[VALUE_W-SLICE_W-1:0], div_q};
    end

    assign rd_idx   = DIG_IDX_W'(r_cnt - 1'b1);
    assign out_free = !r_out_valid || !i_stall;

    // Sequence divide and emit phases
    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_slice     = r_slice;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        o_pop       = 1'b0;
        dig_we      = 1'b0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_quo   = i_job.mag;
                    n_neg   = i_job.neg;
                    n_rem   = '0;
                    n_slice = '0;
                    n_cnt   = '0;
                    n_state = i_job.err ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo   = div_quo;
                n_rem   = div_rem;
                n_slice = r_slice + 1'b1;
                if (r_slice == SLICE_IDX_W'(SLICES - 1)) begin
                    dig_we = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_rem  = '0;
                    if (div_quo == '0 || r_cnt == CNT_W'(MAX_DIGITS - 1)) begin
                        n_state = ST_SIGN;
                    end
                end
            end
            ST_SIGN: begin
                if (!r_neg) begin
                    n_state = ST_EMIT;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_out_err   = 1'b0;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = table_char(r_dig[rd_idx], i_table_lo, i_table_hi);
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_out_err   = 1'b0;
                    n_cnt       = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold working values and the output payload
    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_slice    <= n_slice;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    // Push each finished digit onto the digit stack
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_dig[r_cnt[DIG_IDX_W-1:0]] <= div_rem;
        end
    end

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_last && r_out_char == '0))
        else $error("error result without last or with a character");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIGITS))
        else $error("digit stack overflow");

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("emit phase with empty digit stack");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_cnt == CNT_W'(1)) |=>
            (r_state == ST_IDLE && r_out_valid && r_out_last))
        else $error("final digit not flagged last");

endmodule

`default_nettype wire

/* rtl/signed_radix_digit_emitter_top.sv */
// Top level: configuration registers, front end, request queue and back end.
//
// Converts each signed 32-bit request into its text in the configured radix and
// sends it out one character per result, a minus sign first for negative values,
// then the digits most significant first; the final character carries last. An
// invalid base (radix below 2 or above 16, a plus or minus sign, a byte outside
// 32..126, or a repeated character) gives a single result with base_error set.
// In the back end, the request is first taken from the queue. Each digit then passes
// through the radix divider, which handles 8 bits of the 32-bit dividend per cycle.
// Every value then goes through the sign step, positive values too, and the
// characters are emitted one per cycle while the output is not stalled. Base 2 with
// a full 32-bit magnitude is the slowest case.
// A two-entry request queue lets the front end accept while the back end still works.
`default_nettype none

module signed_radix_digit_emitter_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [srde_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [srde_pkg::CHAR_W-1:0]              o_out_char,
    output logic                                     o_last,
    output logic                                     o_base_error,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [srde_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [srde_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [srde_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import srde_pkg::*;

    logic [BASE_W-1:0]  r_base_size;
    logic [TABLE_W-1:0] r_table_lo;
    logic [TABLE_W-1:0] r_table_hi;
    logic               cfg_wr;
    logic [1:0]         cfg_sel;

    t_job               push_job;
    t_job               pop_job;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_valid;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[CFG_ADDR_W-1:CFG_ADDR_W-2];

    // Write configuration registers; drop writes to unused addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size <= '0;
            r_table_lo  <= '0;
            r_table_hi  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                CFG_BASE_SIZE: r_base_size <= pwdata[BASE_W-1:0];
                CFG_TABLE_LO:  r_table_lo  <= pwdata;
                CFG_TABLE_HI:  r_table_hi  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        unique case (cfg_sel)
            CFG_BASE_SIZE: prdata = CFG_DATA_W'(r_base_size);
            CFG_TABLE_LO:  prdata = r_table_lo;
            CFG_TABLE_HI:  prdata = r_table_hi;
            default:       prdata = '0;
        endcase
    end

    srde_front u_front (
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_base_size (r_base_size),
        .i_table_lo  (r_table_lo),
        .i_table_hi  (r_table_hi),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    srde_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    srde_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (pop_job),
        .o_pop        (pop),
        .i_base_size  (r_base_size),
        .i_table_lo   (r_table_lo),
        .i_table_hi   (r_table_hi),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_last       (o_last),
        .o_base_error (o_base_error)
    );

endmodule

`default_nettype wire
